// File: hw/rtl/cpan_pkg.sv
`default_nettype none
package cpan_pkg;

  localparam int unsigned AES_ROUNDS = 10;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned V4_W       = 32;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_KEY_HIGH = 2'd0;
  localparam cfg_idx_t REG_KEY_LOW  = 2'd1;
  localparam cfg_idx_t REG_PAD_HIGH = 2'd2;
  localparam cfg_idx_t REG_PAD_LOW  = 2'd3;

  localparam logic ACT_V4 = 1'b0;
  localparam logic ACT_V6 = 1'b1;

  // control bits that ride alongside each aes block
  typedef struct packed {
    logic vld;
    logic last;
    logic act;
    logic abit;
  } tag_t;

  typedef logic [127:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i downwards
  function automatic logic [7:0] get_byte(input blk_t s, input int unsigned i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic blk_t aes_round(input blk_t s, input blk_t k, input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    blk_t r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4 * c] = SBOX[get_byte(s, i + 4 * ((c + i) % 4))];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c];
        a1 = t[4 * c + 1];
        a2 = t[4 * c + 2];
        a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = t[i];
    end
    return r ^ k;
  endfunction

  function automatic blk_t key_step(input blk_t w, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t = {SBOX[w[23:16]] ^ rcon, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    w0 = w[127:96] ^ t;
    w1 = w[95:64] ^ w0;
    w2 = w[63:32] ^ w1;
    w3 = w[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8 * i +: 8] = v[56 - 8 * i +: 8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cpan_keysched.sv
`default_nettype none
module cpan_keysched
  import cpan_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire blk_t  key,
  output logic       busy,
  output blk_t       rk [AES_ROUNDS + 1]
);

  logic       busy_r;
  logic [3:0] cnt_r;
  logic [7:0] rcon_r;
  blk_t       w_r;
  blk_t       step;
  blk_t       rk_r [AES_ROUNDS + 1];

  assign step = key_step(w_r, rcon_r);
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd1;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 4'd1;
      if (cnt_r == 4'(AES_ROUNDS)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_r      <= key;
      rcon_r   <= 8'h01;
      rk_r[0]  <= key;
    end else if (busy_r) begin
      w_r    <= step;
      rcon_r <= xtime(rcon_r);
    end
  end

  for (genvar i = 1; i <= AES_ROUNDS; i++) begin : g_rk
    always_ff @(posedge clk) begin
      if (busy_r && !start && cnt_r == 4'(i)) begin
        rk_r[i] <= step;
      end
    end
  end

  always_comb begin
    for (int i = 0; i <= AES_ROUNDS; i++) begin
      rk[i] = rk_r[i];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cpan_aes_pipe.sv
`default_nettype none
module cpan_aes_pipe
  import cpan_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tag_t tag_in,
  input  wire blk_t blk_in,
  input  wire blk_t rk [AES_ROUNDS + 1],
  output tag_t      tag_out,
  output logic      prf_bit
);

  blk_t st_r  [AES_ROUNDS + 1];
  tag_t tag_r [AES_ROUNDS + 1];

  // stage 0 is the initial key add, then one aes round per stage
  always_ff @(posedge clk) begin
    st_r[0] <= blk_in ^ rk[0];
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else begin
      tag_r[0] <= tag_in;
    end
  end

  for (genvar r = 1; r <= AES_ROUNDS; r++) begin : g_rnd
    always_ff @(posedge clk) begin
      st_r[r] <= aes_round(st_r[r - 1], rk[r], (r < AES_ROUNDS) ? 1'b1 : 1'b0);
      if (!rst_n) begin
        tag_r[r] <= '0;
      end else begin
        tag_r[r] <= tag_r[r - 1];
      end
    end
  end

  assign tag_out = tag_r[AES_ROUNDS];
  assign prf_bit = st_r[AES_ROUNDS][127];

endmodule
`default_nettype wire

// File: hw/rtl/cpan_collect.sv
`default_nettype none
module cpan_collect
  import cpan_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tag_t        tag_a,
  input  wire logic        prf_a,
  input  wire tag_t        tag_b,
  input  wire logic        prf_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_anon_high,
  output logic [63:0]      out_anon_low
);

  logic [63:0] acc_a_r, acc_b_r, acc_a_nxt, acc_b_nxt;
  logic [63:0] hi_q_r [2];
  logic [63:0] lo_q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  // address bit xor prf bit shifts in, first position ends on top
  assign acc_a_nxt = {acc_a_r[62:0], tag_a.abit ^ prf_a};
  assign acc_b_nxt = {acc_b_r[62:0], tag_b.abit ^ prf_b};
  assign push = tag_a.vld && tag_a.last;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (tag_a.vld) begin
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
    end
    if (push) begin
      if (tag_a.act == ACT_V6) begin
        hi_q_r[wp_r] <= acc_a_nxt;
        lo_q_r[wp_r] <= acc_b_nxt;
      end else begin
        hi_q_r[wp_r] <= '0;
        lo_q_r[wp_r] <= {32'd0, acc_a_nxt[V4_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid     = (cnt_r != 2'd0);
  assign out_anon_high = hi_q_r[rp_r];
  assign out_anon_low  = lo_q_r[rp_r];

endmodule
`default_nettype wire

// File: hw/rtl/prefix_preserving_ip_anonymizer.sv
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     in_action, in_addr_high, in_addr_low
// out       output     out_valid / out_ready   out_anon_high, out_anon_low
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// an ipv6 request issues 64 blocks to each of two 11-stage aes pipelines, one a cycle,
// and a new request can be taken as its last block issues; an ipv4 request uses 32
// blocks on one pipeline.
// after reset and after a key write in_ready stays low while the round keys expand.
// results land in a two-entry queue; in_ready drops while two requests are outstanding,
// so a stalled output loses nothing and the aes pipelines never stop.
`default_nettype none
module prefix_preserving_ip_anonymizer
  import cpan_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [63:0] in_addr_high,
  input  wire logic [63:0] in_addr_low,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_anon_high,
  output logic [63:0]      out_anon_low,
  input  wire logic        cfg_we,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0] key_high_r, key_low_r, pad_high_r, pad_low_r;
  logic        ks_start_r, ks_busy;
  blk_t        rk [AES_ROUNDS + 1];

  logic        busy_r, act_r;
  logic [5:0]  p_r;
  logic [63:0] ah_r, al_r;
  logic        last_issue, in_acc, out_acc;
  logic [1:0]  outst_r;

  logic [63:0] low64, first6, vh, vl;
  logic [31:0] low32, v4;
  blk_t        blk_a, blk_b;
  tag_t        tin_a, tin_b, tout_a, tout_b;
  logic        prf_a, prf_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      pad_high_r <= '0;
      pad_low_r  <= '0;
      ks_start_r <= 1'b1;
    end else begin
      ks_start_r <= cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: key_high_r <= cfg_data;
          REG_KEY_LOW:  key_low_r  <= cfg_data;
          REG_PAD_HIGH: pad_high_r <= cfg_data;
          REG_PAD_LOW:  pad_low_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  cpan_keysched u_ks (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ks_start_r),
    .key   ({key_high_r, key_low_r}),
    .busy  (ks_busy),
    .rk    (rk)
  );

  assign last_issue = busy_r && (act_r == ACT_V6 ? (p_r == 6'(HALF_W - 1))
                                                  : (p_r == 6'(V4_W - 1)));
  assign in_ready = !ks_start_r && !ks_busy && (outst_r != 2'd2) && (!busy_r || last_issue);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      p_r     <= '0;
      outst_r <= '0;
    end else begin
      outst_r <= outst_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (in_acc) begin
        busy_r <= 1'b1;
        p_r    <= '0;
      end else if (busy_r) begin
        p_r <= p_r + 6'd1;
        if (last_issue) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_action;
      ah_r  <= in_addr_high;
      al_r  <= in_addr_low;
    end
  end

  // prefix of the address above position p, pad below it
  always_comb begin
    low64  = {64{1'b1}} >> p_r;
    low32  = {32{1'b1}} >> p_r[4:0];
    v4     = (al_r[31:0] & ~low32) | (pad_high_r[63:32] & low32);
    first6 = bswap64(pad_high_r);
    vh     = (ah_r & ~low64) | (first6 & low64);
    vl     = (al_r & ~low64) | (first6 & low64);
    if (act_r == ACT_V6) begin
      blk_a = {bswap64(vh), pad_low_r};
      tin_a.abit = ah_r[~p_r];
    end else begin
      blk_a = {v4, pad_high_r[31:0], pad_low_r};
      tin_a.abit = al_r[{1'b0, ~p_r[4:0]}];
    end
    blk_b      = {bswap64(vl), pad_low_r};
    tin_a.vld  = busy_r;
    tin_a.last = last_issue;
    tin_a.act  = act_r;
    tin_b.vld  = busy_r;
    tin_b.last = last_issue;
    tin_b.act  = act_r;
    tin_b.abit = al_r[~p_r];
  end

  cpan_aes_pipe u_aes_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tin_a),
    .blk_in  (blk_a),
    .rk      (rk),
    .tag_out (tout_a),
    .prf_bit (prf_a)
  );

  cpan_aes_pipe u_aes_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tin_b),
    .blk_in  (blk_b),
    .rk      (rk),
    .tag_out (tout_b),
    .prf_bit (prf_b)
  );

  cpan_collect u_col (
    .clk           (clk),
    .rst_n         (rst_n),
    .tag_a         (tout_a),
    .prf_a         (prf_a),
    .tag_b         (tout_b),
    .prf_b         (prf_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_anon_high (out_anon_high),
    .out_anon_low  (out_anon_low)
  );

  a_outst_max: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r != 2'd3) else $error("outstanding count overflow");

  a_out_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outst_r != 2'd0) else $error("result without request");

  a_pipes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    tout_a.vld == tout_b.vld && tout_a.last == tout_b.last)
    else $error("aes pipelines out of step");

  a_no_issue_in_ks: assert property (@(posedge clk) disable iff (!rst_n)
    ks_busy |-> !in_ready) else $error("request taken during key expansion");

endmodule
`default_nettype wire
